// File: src/pose_frame_point_transform_assert.svh
// ---------------------------------------------------------------------------
// pose frame transform assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef POSE_FRAME_POINT_TRANSFORM_ASSERT_SVH
`define POSE_FRAME_POINT_TRANSFORM_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PFPT_ASSERT_IMPL(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> con) \
    else $error("pfpt assertion failed");

// antecedent implies consequent in the next cycle
`define PFPT_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("pfpt assertion failed");

`endif

// File: src/pfpt_pkg.sv
// ---------------------------------------------------------------------------
// pfpt_pkg
// word types, register indexes and cordic angle table for the frame transform
// ---------------------------------------------------------------------------
package pfpt_pkg;

  localparam int COORD_BITS   = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int TRIG_BITS    = 18;
  localparam int CORDIC_STEPS = 25;
  localparam int IDX_BITS     = 8;
  localparam int CFG_BITS     = 32;

  localparam logic [IDX_BITS-1:0] REG_POSE_A_X   = 8'd0;
  localparam logic [IDX_BITS-1:0] REG_POSE_A_Y   = 8'd1;
  localparam logic [IDX_BITS-1:0] REG_POSE_A_YAW = 8'd2;
  localparam logic [IDX_BITS-1:0] REG_POSE_B_X   = 8'd3;
  localparam logic [IDX_BITS-1:0] REG_POSE_B_Y   = 8'd4;
  localparam logic [IDX_BITS-1:0] REG_POSE_B_YAW = 8'd5;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [ANGLE_BITS-1:0] heading_in;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [ANGLE_BITS-1:0] heading_out;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [ANGLE_BITS-1:0] a_yaw;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [ANGLE_BITS-1:0] b_yaw;
    logic signed [TRIG_BITS-1:0]  cos_a;
    logic signed [TRIG_BITS-1:0]  sin_a;
    logic signed [TRIG_BITS-1:0]  cos_b;
    logic signed [TRIG_BITS-1:0]  sin_b;
  } pose_t;

  // atan(2^-i) in turn units of 2^-32
  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      5'd24:   v = 30'd41;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// File: src/pfpt_cordic.sv
// ---------------------------------------------------------------------------
// pfpt_cordic
// iterative cordic, one micro-rotation per cycle, cosine and sine in q16
// ---------------------------------------------------------------------------
module pfpt_cordic (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     go_i,
  input  logic signed [pfpt_pkg::ANGLE_BITS-1:0]  yaw_i,
  output logic                                     busy_o,
  output logic signed [pfpt_pkg::TRIG_BITS-1:0]   cos_o,
  output logic signed [pfpt_pkg::TRIG_BITS-1:0]   sin_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_ITER = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;
  localparam logic [4:0] LAST_STEP = 5'(pfpt_pkg::CORDIC_STEPS - 1);
  localparam int TB = pfpt_pkg::TRIG_BITS;

  logic [1:0]         state_q, state_d;
  logic [4:0]         step_q, step_d;
  logic [1:0]         quad_q, quad_d;
  logic signed [32:0] x_q, x_d, y_q, y_d, r_q, r_d;
  logic signed [TB-1:0] cos_q, cos_d, sin_q, sin_d;

  logic [31:0]        u, ur, rd;
  logic [1:0]         q;
  logic signed [32:0] dx, dy, at, xr, yr;
  logic signed [TB-1:0] cc, ss;

  always_comb begin
    u  = {yaw_i, {(32 - pfpt_pkg::ANGLE_BITS){1'b0}}};
    ur = u + 32'h2000_0000;
    q  = ur[31:30];
    rd = u - {q, 30'd0};
    dx = y_q >>> step_q;
    dy = x_q >>> step_q;
    at = $signed({3'b000, pfpt_pkg::atan_entry(step_q)});
    xr = x_q + 33'sd8192;
    yr = y_q + 33'sd8192;
    cc = xr[31:14];
    ss = yr[31:14];
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    quad_d  = quad_q;
    x_d     = x_q;
    y_d     = y_q;
    r_d     = r_q;
    cos_d   = cos_q;
    sin_d   = sin_q;
    unique case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        quad_d  = q;
        x_d     = 33'sd652032874;
        y_d     = '0;
        r_d     = 33'($signed(rd));
        step_d  = '0;
        state_d = ST_ITER;
      end
      ST_ITER: begin
        if (!r_q[32]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          r_d = r_q - at;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          r_d = r_q + at;
        end
        step_d = step_q + 5'd1;
        if (step_q == LAST_STEP) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        case (quad_q)
          2'd0:    begin cos_d = cc;  sin_d = ss;  end
          2'd1:    begin cos_d = -ss; sin_d = cc;  end
          2'd2:    begin cos_d = -cc; sin_d = -ss; end
          default: begin cos_d = ss;  sin_d = -cc; end
        endcase
        state_d = go_i ? ST_LOAD : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (go_i && state_q != ST_IDLE) begin
      state_d = ST_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q <= quad_d;
    x_q    <= x_d;
    y_q    <= y_d;
    r_q    <= r_d;
    cos_q  <= cos_d;
    sin_q  <= sin_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule

// File: src/pfpt_datapath.sv
// ---------------------------------------------------------------------------
// pfpt_datapath
// four stage pipeline: rotate by a, translate, rotate by minus b, saturate
// ---------------------------------------------------------------------------
module pfpt_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  pfpt_pkg::in_word_t   word_i,
  input  pfpt_pkg::pose_t      pose_i,
  output logic                 valid_o,
  output pfpt_pkg::out_word_t  word_o
);

  localparam int C  = pfpt_pkg::COORD_BITS;
  localparam int A  = pfpt_pkg::ANGLE_BITS;
  localparam int T  = pfpt_pkg::TRIG_BITS;
  localparam int P1 = C + T;
  localparam int W1 = P1 + 1;
  localparam int XB = C + 5;
  localparam int P2 = XB + T;
  localparam int W2 = P2 + 1;
  localparam logic signed [W2-1:0] SAT_HI = $signed(W2'({1'b0, {(C-1){1'b1}}}));
  localparam logic signed [W2-1:0] SAT_LO = -SAT_HI - W2'(1);
  localparam logic signed [W1-1:0] RND1 = W1'(32768);
  localparam logic signed [W2-1:0] RND2 = W2'(32768);

  logic [3:0] vld_q;

  logic signed [P1-1:0] m_xc_q, m_ys_q, m_xs_q, m_yc_q;
  logic signed [A-1:0]  hd1_q, hd2_q, hd3_q;
  logic signed [W1-1:0] sx, sy;
  logic signed [XB-1:0] xb_q, xb_d, yb_q, yb_d;
  logic signed [P2-1:0] n_xc_q, n_ys_q, n_xs_q, n_yc_q;
  logic signed [W2-1:0] tx, ty, rx, ry;
  pfpt_pkg::out_word_t  out_q, out_d;

  always_comb begin
    sx   = W1'(m_xc_q) - W1'(m_ys_q) + RND1;
    sy   = W1'(m_xs_q) + W1'(m_yc_q) + RND1;
    xb_d = XB'(pose_i.a_x) - XB'(pose_i.b_x) + XB'(sx >>> 16);
    yb_d = XB'(pose_i.a_y) - XB'(pose_i.b_y) + XB'(sy >>> 16);
    tx   = W2'(n_xc_q) + W2'(n_ys_q) + RND2;
    ty   = W2'(n_yc_q) - W2'(n_xs_q) + RND2;
    rx   = tx >>> 16;
    ry   = ty >>> 16;
    out_d.out_x       = (rx > SAT_HI) ? C'(SAT_HI) : (rx < SAT_LO) ? C'(SAT_LO) : C'(rx);
    out_d.out_y       = (ry > SAT_HI) ? C'(SAT_HI) : (ry < SAT_LO) ? C'(SAT_LO) : C'(ry);
    out_d.heading_out = hd3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    m_xc_q <= word_i.point_x * pose_i.cos_a;
    m_ys_q <= word_i.point_y * pose_i.sin_a;
    m_xs_q <= word_i.point_x * pose_i.sin_a;
    m_yc_q <= word_i.point_y * pose_i.cos_a;
    hd1_q  <= word_i.heading_in + pose_i.a_yaw - pose_i.b_yaw;
    xb_q   <= xb_d;
    yb_q   <= yb_d;
    hd2_q  <= hd1_q;
    n_xc_q <= xb_q * pose_i.cos_b;
    n_ys_q <= yb_q * pose_i.sin_b;
    n_xs_q <= xb_q * pose_i.sin_b;
    n_yc_q <= yb_q * pose_i.cos_b;
    hd3_q  <= hd2_q;
    out_q  <= out_d;
  end

  assign valid_o = vld_q[3];
  assign word_o  = out_q;

endmodule

// File: src/pose_frame_point_transform.sv
// ---------------------------------------------------------------------------
// pose_frame_point_transform
// moves a point and heading from the frame of pose a to the frame of pose b
//
//   channel  signals                                      direction
//   config   cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i  in
//   command  start_i busy_o in_i                           in
//   result   valid_o out_o                                 out
//
// one word per cycle while busy_o is low; a result passes through the four
// pipeline register stages around the two multiplier banks.
// after reset and after any yaw write, busy_o stays high while the cordic
// unit recomputes cosine and sine.
// the receiver cannot stall; results are shown for one cycle on valid_o.
// ---------------------------------------------------------------------------
`include "pose_frame_point_transform_assert.svh"

module pose_frame_point_transform (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pfpt_pkg::IDX_BITS-1:0]       cfg_index_i,
  input  logic [pfpt_pkg::CFG_BITS-1:0]       cfg_data_i,
  input  logic                                start_i,
  output logic                                busy_o,
  input  pfpt_pkg::in_word_t                  in_i,
  output logic                                valid_o,
  output pfpt_pkg::out_word_t                 out_o
);

  localparam int C = pfpt_pkg::COORD_BITS;
  localparam int A = pfpt_pkg::ANGLE_BITS;

  logic signed [C-1:0] a_x_q, a_y_q, b_x_q, b_y_q;
  logic signed [A-1:0] a_yaw_q, b_yaw_q;
  logic                wr, go_a, go_b, busy_a, busy_b, accept;
  pfpt_pkg::pose_t     pose;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;
  assign go_a        = wr && (cfg_index_i == pfpt_pkg::REG_POSE_A_YAW);
  assign go_b        = wr && (cfg_index_i == pfpt_pkg::REG_POSE_B_YAW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_x_q   <= '0;
      a_y_q   <= '0;
      a_yaw_q <= '0;
      b_x_q   <= '0;
      b_y_q   <= '0;
      b_yaw_q <= '0;
    end else if (wr) begin
      unique case (cfg_index_i)
        pfpt_pkg::REG_POSE_A_X:   a_x_q   <= C'(cfg_data_i);
        pfpt_pkg::REG_POSE_A_Y:   a_y_q   <= C'(cfg_data_i);
        pfpt_pkg::REG_POSE_A_YAW: a_yaw_q <= A'(cfg_data_i);
        pfpt_pkg::REG_POSE_B_X:   b_x_q   <= C'(cfg_data_i);
        pfpt_pkg::REG_POSE_B_Y:   b_y_q   <= C'(cfg_data_i);
        pfpt_pkg::REG_POSE_B_YAW: b_yaw_q <= A'(cfg_data_i);
        default: ;
      endcase
    end
  end

  pfpt_cordic u_trig_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go_a),
    .yaw_i  (a_yaw_q),
    .busy_o (busy_a),
    .cos_o  (pose.cos_a),
    .sin_o  (pose.sin_a)
  );

  pfpt_cordic u_trig_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go_b),
    .yaw_i  (b_yaw_q),
    .busy_o (busy_b),
    .cos_o  (pose.cos_b),
    .sin_o  (pose.sin_b)
  );

  assign pose.a_x   = a_x_q;
  assign pose.a_y   = a_y_q;
  assign pose.a_yaw = a_yaw_q;
  assign pose.b_x   = b_x_q;
  assign pose.b_y   = b_y_q;
  assign pose.b_yaw = b_yaw_q;

  assign busy_o = busy_a || busy_b;
  assign accept = start_i && !busy_o;

  pfpt_datapath u_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .word_i  (in_i),
    .pose_i  (pose),
    .valid_o (valid_o),
    .word_o  (out_o)
  );

  `PFPT_ASSERT_IMPL(a_latency, accept, ##4 valid_o)
  `PFPT_ASSERT_IMPL(a_no_ghost, valid_o, $past(accept, 4))
  `PFPT_ASSERT_NEXT(a_yaw_busy, go_a || go_b, busy_o)

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the pose a to pose b frame transform: a queue-fed
// driver sends point words, a frame predictor computes the expected word on
// acceptance, and a monitor compares every strobed result with the oldest
// expectation while the poses are rewritten between phases
// ---------------------------------------------------------------------------
module tb_top;

  localparam longint ATAN_TURN [pfpt_pkg::CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41};

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [pfpt_pkg::IDX_BITS-1:0] cfg_index_i = '0;
  logic [pfpt_pkg::CFG_BITS-1:0] cfg_data_i = '0;
  logic                          start_i = 1'b0;
  logic                          busy_o;
  pfpt_pkg::in_word_t            in_i = '0;
  logic                          valid_o;
  pfpt_pkg::out_word_t           out_o;

  logic signed [pfpt_pkg::COORD_BITS-1:0] pose_ax, pose_ay, pose_bx, pose_by;
  logic signed [pfpt_pkg::ANGLE_BITS-1:0] pose_ayaw, pose_byaw;

  pfpt_pkg::in_word_t  pending_words[$];
  pfpt_pkg::out_word_t frame_b_words[$];
  int                  send_idle_pct = 22;
  int                  errors = 0;

  pose_frame_point_transform dut (.*);

  always #6 clk_i = ~clk_i;

  // cordic sine and cosine in q16
  function automatic void yaw_trig(input logic [pfpt_pkg::ANGLE_BITS-1:0] ang,
                                   output longint c, output longint s);
    logic [31:0] u, d;
    logic [1:0]  q;
    longint      r, x, y, dx, dy, cc, ss;
    u = {ang, 16'h0};
    q = 2'((u + 32'h2000_0000) >> 30);
    d = u - {q, 30'b0};
    r = longint'($signed(d));
    x = 652032874;
    y = 0;
    for (int i = 0; i < pfpt_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (r >= 0) begin
        x -= dx; y += dy; r -= ATAN_TURN[i];
      end else begin
        x += dx; y -= dy; r += ATAN_TURN[i];
      end
    end
    cc = (x + 8192) >>> 14;
    ss = (y + 8192) >>> 14;
    case (q)
      2'd0: begin c = cc;  s = ss;  end
      2'd1: begin c = -ss; s = cc;  end
      2'd2: begin c = -cc; s = -ss; end
      default: begin c = ss; s = -cc; end
    endcase
  endfunction

  function automatic longint mac_q16(longint a, longint ka, longint b, longint kb);
    return (a * ka + b * kb + 32768) >>> 16;
  endfunction

  function automatic logic [pfpt_pkg::COORD_BITS-1:0] clamp_coord(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[pfpt_pkg::COORD_BITS-1:0];
  endfunction

  function automatic pfpt_pkg::out_word_t to_frame_b(pfpt_pkg::in_word_t w);
    longint              ca, sa, cb, sb, xw, yw, xb, yb;
    pfpt_pkg::out_word_t o;
    yaw_trig(pose_ayaw, ca, sa);
    yaw_trig(pose_byaw, cb, sb);
    xw = longint'(pose_ax) + mac_q16(longint'(w.point_x), ca, longint'(w.point_y), -sa);
    yw = longint'(pose_ay) + mac_q16(longint'(w.point_x), sa, longint'(w.point_y), ca);
    xb = xw - longint'(pose_bx);
    yb = yw - longint'(pose_by);
    o.out_x = clamp_coord(mac_q16(xb, cb, yb, sb));
    o.out_y = clamp_coord(mac_q16(xb, -sb, yb, cb));
    o.heading_out = w.heading_in + pose_ayaw - pose_byaw;
    return o;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (start_i && !busy_o) frame_b_words.push_back(to_frame_b(in_i));
    if (!(start_i && busy_o)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        start_i <= 1'b1;
        in_i    <= pending_words.pop_front();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (frame_b_words.size() == 0) begin
        $display("%0t unexpected word %h", $time, out_o);
        errors++;
      end else begin
        pfpt_pkg::out_word_t e;
        e = frame_b_words.pop_front();
        if (out_o.out_x !== e.out_x) begin
          $display("%0t out_x exp %0d got %0d", $time, e.out_x, out_o.out_x);
          errors++;
        end
        if (out_o.out_y !== e.out_y) begin
          $display("%0t out_y exp %0d got %0d", $time, e.out_y, out_o.out_y);
          errors++;
        end
        if (out_o.heading_out !== e.heading_out) begin
          $display("%0t heading_out exp %0d got %0d", $time, e.heading_out,
                   out_o.heading_out);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(logic [pfpt_pkg::IDX_BITS-1:0] idx,
                           logic [pfpt_pkg::CFG_BITS-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      pfpt_pkg::REG_POSE_A_X:   pose_ax   = data;
      pfpt_pkg::REG_POSE_A_Y:   pose_ay   = data;
      pfpt_pkg::REG_POSE_A_YAW: pose_ayaw = data[pfpt_pkg::ANGLE_BITS-1:0];
      pfpt_pkg::REG_POSE_B_X:   pose_bx   = data;
      pfpt_pkg::REG_POSE_B_Y:   pose_by   = data;
      pfpt_pkg::REG_POSE_B_YAW: pose_byaw = data[pfpt_pkg::ANGLE_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_poses(logic [31:0] ax, logic [31:0] ay, logic [31:0] ayaw,
                           logic [31:0] bx, logic [31:0] by, logic [31:0] byaw);
    reg_write(pfpt_pkg::REG_POSE_A_X, ax);
    reg_write(pfpt_pkg::REG_POSE_A_Y, ay);
    reg_write(pfpt_pkg::REG_POSE_A_YAW, ayaw);
    reg_write(pfpt_pkg::REG_POSE_B_X, bx);
    reg_write(pfpt_pkg::REG_POSE_B_Y, by);
    reg_write(pfpt_pkg::REG_POSE_B_YAW, byaw);
    reg_write(pfpt_pkg::IDX_BITS'($urandom_range(255, 6)), $urandom);
  endtask

  task automatic drain;
    do @(posedge clk_i);
    while (pending_words.size() != 0 || start_i || frame_b_words.size() != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic queue_random(int n);
    pfpt_pkg::in_word_t w;
    repeat (n) begin
      w.point_x    = $urandom;
      w.point_y    = $urandom;
      w.heading_in = $urandom;
      if ($urandom_range(3) == 0) begin
        w.point_x = $signed(w.point_x) >>> $urandom_range(31, 8);
        w.point_y = $signed(w.point_y) >>> $urandom_range(31, 8);
      end
      pending_words.push_back(w);
    end
  endtask

  task automatic queue_edges;
    logic signed [pfpt_pkg::COORD_BITS-1:0] ext[4] = '{32'h7fff_ffff, 32'h8000_0000, 0, -1};
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        pending_words.push_back('{ext[i], ext[j], 16'(i * 4 + j) << 12});
    pending_words.push_back('{32'sd1024, -32'sd2048, 16'h7fff});
    pending_words.push_back('{-32'sd1024, 32'sd512, 16'h8000});
  endtask

  initial begin
    pose_ax = 0; pose_ay = 0; pose_bx = 0; pose_by = 0;
    pose_ayaw = 0; pose_byaw = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_edges();
    drain();
    set_poses(32'h7fff_ffff, 32'h8000_0000, 32'h0000_4000,
              32'h8000_0000, 32'h7fff_ffff, 32'hffff_8000);
    queue_edges();
    drain();
    set_poses(32'h8000_0000, 32'h7fff_ffff, 32'h0000_2000,
              32'h7fff_ffff, 32'h8000_0000, 32'h1234_dfff);
    queue_edges();
    drain();
    for (int ph = 0; ph < 9; ph++) begin
      send_idle_pct = (ph < 3) ? 22 : (ph < 6) ? 86 : 0;
      set_poses($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      queue_random(67);
      drain();
    end
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
